FILE: src/tpr_pkg.sv
// Shared types, constants and codes for the tight palette pixel to RGBA converter.
package tpr_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int RAW_W         = 32;
    localparam int NUM_W         = 16;
    localparam int DEN_W         = 32;
    localparam int Q_W           = 8;
    localparam int LANES         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [3:0]  RST_FORMAT_MODE = 4'd11;
    localparam logic [4:0]  RST_RED_SHIFT   = 5'd16;
    localparam logic [4:0]  RST_GREEN_SHIFT = 5'd8;
    localparam logic [4:0]  RST_BLUE_SHIFT  = 5'd0;
    localparam logic [15:0] RST_COMP_MAX    = 16'd255;
    localparam logic [5:0]  RST_COLOR_DEPTH = 6'd24;
    localparam logic [7:0]  FULL_SCALE      = 8'd255;
    localparam logic [3:0]  MAX_BITMAP_PIX  = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DIRECT = 2'd1,
        OP_INDEX  = 2'd2,
        OP_BITMAP = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE = 3'd0,
        CFG_RED_SHIFT   = 3'd1,
        CFG_GREEN_SHIFT = 3'd2,
        CFG_BLUE_SHIFT  = 3'd3,
        CFG_RED_MAX     = 3'd4,
        CFG_GREEN_MAX   = 3'd5,
        CFG_BLUE_MAX    = 3'd6,
        CFG_COLOR_DEPTH = 3'd7
    } cfg_idx_t;

    typedef logic [LANES-1:0][NUM_W-1:0] div_num_t;
    typedef logic [LANES-1:0][DEN_W-1:0] div_den_t;
    typedef logic [LANES-1:0][Q_W-1:0]   div_quo_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: src/tpr_if.sv
// Input and output channel interfaces of the tight palette pixel to RGBA converter.
interface tpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] value;
    logic [7:0]  entry_index;
    logic [3:0]  valid_pixels;

    modport source (output valid, output operation, output value, output entry_index,
                    output valid_pixels, input ready);
    modport sink   (input valid, input operation, input value, input entry_index,
                    input valid_pixels, output ready);
endinterface

interface tpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output last, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input last, output ready);
endinterface

FILE: src/tpr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tpr_div4.sv
// Four restoring dividers in parallel, one quotient bit per lane each cycle.
module tpr_div4 (
    input  logic               clk,
    input  logic               rst_n,
    input  tpr_pkg::div_ctrl_t ctrl,
    input  tpr_pkg::div_num_t  num,
    input  tpr_pkg::div_den_t  den,
    output tpr_pkg::div_stat_t stat,
    output tpr_pkg::div_quo_t  quo
);

    localparam int SH_W = tpr_pkg::DEN_W + tpr_pkg::Q_W - 1;

    logic                                     busy_reg;
    logic                                     done_reg;
    logic [$clog2(tpr_pkg::Q_W)-1:0]          cnt_reg;
    logic [tpr_pkg::LANES-1:0][tpr_pkg::NUM_W-1:0] rem_reg;
    logic [tpr_pkg::LANES-1:0][SH_W-1:0]      dsh_reg;
    tpr_pkg::div_quo_t                        quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == $bits(cnt_reg)'(tpr_pkg::Q_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Each lane compares the remainder against the divisor scaled to the current
    // quotient bit; the quotient is known to fit in eight bits.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tpr_pkg::LANES; i++)
        begin
            if (ctrl.start)
            begin
                rem_reg[i] <= num[i];
                dsh_reg[i] <= {den[i], {(tpr_pkg::Q_W - 1){1'b0}}};
                quo_reg[i] <= '0;
            end
            else if (busy_reg)
            begin
                if (SH_W'(rem_reg[i]) >= dsh_reg[i])
                begin
                    rem_reg[i] <= rem_reg[i] - dsh_reg[i][tpr_pkg::NUM_W-1:0];
                    quo_reg[i] <= {quo_reg[i][tpr_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[i] <= {quo_reg[i][tpr_pkg::Q_W-2:0], 1'b0};
                end
                dsh_reg[i] <= dsh_reg[i] >> 1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");

    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done at once");

endmodule

FILE: src/tight_palette_pixel_to_rgba.sv
// Top level: tight palette and raw pixel to RGBA converter with palette RAM.
//
//  Channel   Kind              Transfer when           Carries
//  pix_in    valid/ready sink  valid & ready at clk    operation, value, entry_index,
//                                                      valid_pixels
//  pix_out   valid/ready src   valid & ready at clk    red, green, blue, alpha, last
//  cfg       write only        cfg_we at clk           cfg_index, cfg_data
//
// A load item writes its palette entry as it is taken in. Each output pixel runs
// through a palette RAM read, a step to assemble the pixel and set up the
// components, the four-lane bit-serial divider that scales by 255 / max, and a
// hand-off of the pixel to the output register. A direct pixel skips the RAM
// read. A bitmap byte of n pixels repeats these steps for each pixel. Reset clears
// all control state; the palette RAM is not cleared, and an entry must be loaded
// before it is read. A stalled output holds the sequencer before the next pixel;
// the final pixel of an item may wait in the output register while the next item
// is taken in.
module tight_palette_pixel_to_rgba (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0]      cfg_data,
    tpr_in_if.sink                              pix_in,
    tpr_out_if.source                           pix_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CONV,
        S_DIV
    } state_t;

    localparam int PDW = $clog2(tpr_pkg::PALETTE_DEPTH + 1);

    // Configuration registers.
    logic [3:0]  format_mode_reg;
    logic [4:0]  red_shift_reg;
    logic [4:0]  green_shift_reg;
    logic [4:0]  blue_shift_reg;
    logic [15:0] red_max_reg;
    logic [15:0] green_max_reg;
    logic [15:0] blue_max_reg;
    logic [5:0]  color_depth_reg;

    // Sequencer state.
    state_t                       state_reg;
    logic [3:0]                   cnt_reg;
    logic [7:0]                   bits_reg;
    logic                         oob_reg;
    logic [tpr_pkg::RAW_W-1:0]    raw_reg;
    logic [2:0]                   zero_reg;
    logic                         opaque_reg;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic       last_reg;

    logic                          in_xfer;
    logic                          out_free;
    logic                          out_load;
    tpr_pkg::op_t                  op;
    logic [3:0]                    nvalid;
    logic                          idx_in_range;
    logic                          load_in_range;

    logic                          ram_we;
    logic                          ram_re;
    logic [tpr_pkg::PAL_AW-1:0]    ram_raddr;
    logic [tpr_pkg::RAW_W-1:0]     ram_rdata;

    tpr_pkg::div_ctrl_t            div_ctrl;
    tpr_pkg::div_stat_t            div_stat;
    tpr_pkg::div_num_t             div_num;
    tpr_pkg::div_den_t             div_den;
    tpr_pkg::div_quo_t             div_quo;

    // Pixel assembly and component extraction.
    logic                          packed_mode;
    logic                          rev;
    logic [2:0]                    nbytes;
    logic [1:0]                    pos;
    logic [tpr_pkg::RAW_W-1:0]     pix;
    logic [5:0]                    pix_bits;
    logic [5:0]                    abits;
    logic [32:0]                   amax_wide;
    logic [31:0]                   amax;
    logic [31:0]                   pix_sh;
    logic [7:0]                    comp [3];
    logic [7:0]                    acomp;
    logic [15:0]                   cmax [3];
    logic [4:0]                    cshift [3];

    assign in_xfer  = pix_in.valid && pix_in.ready;
    assign out_free = !out_valid_reg || pix_out.ready;
    assign out_load = (state_reg == S_DIV) && div_stat.done && out_free;
    assign op       = tpr_pkg::op_t'(pix_in.operation);
    assign nvalid   = (pix_in.valid_pixels > tpr_pkg::MAX_BITMAP_PIX) ?
                      tpr_pkg::MAX_BITMAP_PIX : pix_in.valid_pixels;
    assign idx_in_range  = PDW'(pix_in.value[7:0]) < PDW'(tpr_pkg::PALETTE_DEPTH);
    assign load_in_range = PDW'(pix_in.entry_index) < PDW'(tpr_pkg::PALETTE_DEPTH);

    assign pix_in.ready = (state_reg == S_IDLE);

    // Palette reads come from a new index or bitmap item, or from the next bit of
    // a bitmap byte once the current pixel moves to the output register. Items are
    // handled one at a time, so a read never overlaps a load of the same entry.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (in_xfer && op == tpr_pkg::OP_INDEX)
        begin
            ram_re    = 1'b1;
            ram_raddr = pix_in.value[tpr_pkg::PAL_AW-1:0];
        end
        else if (in_xfer && op == tpr_pkg::OP_BITMAP)
        begin
            ram_re    = 1'b1;
            ram_raddr = tpr_pkg::PAL_AW'(pix_in.value[7]);
        end
        else if (out_load && cnt_reg > 4'd1)
        begin
            ram_re    = 1'b1;
            ram_raddr = tpr_pkg::PAL_AW'(bits_reg[6]);
        end
    end

    assign ram_we = in_xfer && op == tpr_pkg::OP_LOAD && load_in_range;

    tpr_ram #(
        .WIDTH (tpr_pkg::RAW_W),
        .DEPTH (tpr_pkg::PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pix_in.entry_index[tpr_pkg::PAL_AW-1:0]),
        .wdata (pix_in.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Byte order: packed mode always uses three reversed bytes; otherwise the
    // swap bit reverses the configured number of bytes.
    always_comb
    begin
        packed_mode = format_mode_reg[3];
        rev         = packed_mode || format_mode_reg[2];
        nbytes      = packed_mode ? 3'd3 : ({1'b0, format_mode_reg[1:0]} + 3'd1);
        pix         = '0;
        pos         = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < nbytes)
            begin
                pos = rev ? 2'(nbytes - 3'(k) - 3'd1) : 2'(k);
                pix = pix | (tpr_pkg::RAW_W'(raw_reg[8*k +: 8]) << {pos, 3'b000});
            end
        end
    end

    assign cmax[0]   = red_max_reg;
    assign cmax[1]   = green_max_reg;
    assign cmax[2]   = blue_max_reg;
    assign cshift[0] = red_shift_reg;
    assign cshift[1] = green_shift_reg;
    assign cshift[2] = blue_shift_reg;

    // The alpha field width follows the configured bytes per pixel, not packed mode.
    always_comb
    begin
        pix_bits  = {({1'b0, format_mode_reg[1:0]} + 3'd1), 3'b000};
        abits     = pix_bits - color_depth_reg;
        amax_wide = (color_depth_reg < pix_bits) ? ((33'd1 << abits) - 33'd1) : '0;
        amax      = amax_wide[31:0];
        pix_sh    = pix >> color_depth_reg;
        acomp     = pix_sh[7:0] & amax[7:0];
        for (int c = 0; c < 3; c++)
        begin
            comp[c]       = 8'((pix >> cshift[c]) & tpr_pkg::RAW_W'(cmax[c][7:0]));
            div_num[c]    = {comp[c], 8'h00} - {8'h00, comp[c]};
            div_den[c]    = tpr_pkg::DEN_W'(cmax[c]);
        end
        div_num[3] = {acomp, 8'h00} - {8'h00, acomp};
        div_den[3] = amax;
    end

    assign div_ctrl.start = (state_reg == S_CONV);

    tpr_div4 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= tpr_pkg::RST_FORMAT_MODE;
            red_shift_reg   <= tpr_pkg::RST_RED_SHIFT;
            green_shift_reg <= tpr_pkg::RST_GREEN_SHIFT;
            blue_shift_reg  <= tpr_pkg::RST_BLUE_SHIFT;
            red_max_reg     <= tpr_pkg::RST_COMP_MAX;
            green_max_reg   <= tpr_pkg::RST_COMP_MAX;
            blue_max_reg    <= tpr_pkg::RST_COMP_MAX;
            color_depth_reg <= tpr_pkg::RST_COLOR_DEPTH;
        end
        else if (cfg_we)
        begin
            unique case (tpr_pkg::cfg_idx_t'(cfg_index))
                tpr_pkg::CFG_FORMAT_MODE: format_mode_reg <= cfg_data[3:0];
                tpr_pkg::CFG_RED_SHIFT:   red_shift_reg   <= cfg_data[4:0];
                tpr_pkg::CFG_GREEN_SHIFT: green_shift_reg <= cfg_data[4:0];
                tpr_pkg::CFG_BLUE_SHIFT:  blue_shift_reg  <= cfg_data[4:0];
                tpr_pkg::CFG_RED_MAX:     red_max_reg     <= cfg_data;
                tpr_pkg::CFG_GREEN_MAX:   green_max_reg   <= cfg_data;
                tpr_pkg::CFG_BLUE_MAX:    blue_max_reg    <= cfg_data;
                tpr_pkg::CFG_COLOR_DEPTH: color_depth_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        unique case (op)
                            tpr_pkg::OP_LOAD: ;
                            tpr_pkg::OP_DIRECT:
                            begin
                                cnt_reg   <= 4'd1;
                                state_reg <= S_CONV;
                            end
                            tpr_pkg::OP_INDEX:
                            begin
                                cnt_reg   <= 4'd1;
                                state_reg <= S_READ;
                            end
                            tpr_pkg::OP_BITMAP:
                            begin
                                cnt_reg <= nvalid;
                                if (nvalid != 4'd0)
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: state_reg <= S_CONV;
                S_CONV: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (out_load)
                    begin
                        cnt_reg   <= cnt_reg - 4'd1;
                        state_reg <= (cnt_reg > 4'd1) ? S_READ : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            raw_reg  <= pix_in.value;
            bits_reg <= pix_in.value[7:0];
            oob_reg  <= (op == tpr_pkg::OP_INDEX) && !idx_in_range;
        end
        if (state_reg == S_READ)
        begin
            raw_reg <= oob_reg ? '0 : ram_rdata;
        end
        if (state_reg == S_CONV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                zero_reg[c] <= (cmax[c] == '0);
            end
            opaque_reg <= packed_mode || (amax == '0);
        end
        if (out_load)
        begin
            bits_reg  <= {bits_reg[6:0], 1'b0};
            red_reg   <= zero_reg[0] ? 8'd0 : div_quo[0];
            green_reg <= zero_reg[1] ? 8'd0 : div_quo[1];
            blue_reg  <= zero_reg[2] ? 8'd0 : div_quo[2];
            alpha_reg <= opaque_reg ? tpr_pkg::FULL_SCALE : div_quo[3];
            last_reg  <= (cnt_reg == 4'd1);
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.red   = red_reg;
    assign pix_out.green = green_reg;
    assign pix_out.blue  = blue_reg;
    assign pix_out.alpha = alpha_reg;
    assign pix_out.last  = last_reg;

    a_busy_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> cnt_reg != 4'd0)
        else $error("sequencer active with no pixels left");

    a_read_then_conv: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_CONV)
        else $error("palette read not followed by conversion");

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.ready |-> !div_stat.busy)
        else $error("input ready while divider runs");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DIV)
        else $error("output loaded outside divide state");

endmodule
